>>> rtl/assert_macros.svh
// assertion macros used by the top-level rtl file to check its own logic
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on clk, idle while arst_n is low
`define KSL_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked on clk, idle while arst_n is low
`define KSL_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/ksl_pkg.sv
// shared types and constants of the keyed slot table
`timescale 1ns / 1ps

package ksl_pkg;

	localparam int KEY_W  = 16;
	localparam int DATA_W = 64;
	localparam int IDX_W  = 4;

	// request operation codes
	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_DELETE = 2'd1,
		OP_MODIFY = 2'd2,
		OP_LOOKUP = 2'd3
	} op_t;

	// result status codes
	typedef enum logic [1:0] {
		ST_DONE      = 2'd0,
		ST_FULL      = 2'd1,
		ST_NOT_FOUND = 2'd2
	} status_t;

	// what the back end has to do with a request
	typedef struct packed {
		logic is_insert;
		logic clr_valid;
		logic wr_payload;
		logic rd_payload;
	} cls_t;

	// classified request as it sits in the request queue
	typedef struct packed {
		cls_t              cls;
		logic [KEY_W-1:0]  key;
		logic [DATA_W-1:0] payload;
	} req_t;

	// one result as it sits in the result queue
	typedef struct packed {
		status_t           status;
		logic [IDX_W-1:0]  slot_index;
		logic [DATA_W-1:0] read_payload;
	} res_t;

endpackage

>>> rtl/keyed_slot_table_engine.sv
// top level of the keyed slot table: front end, back end and checks
//
//  channel   handshake        payload
//  request   push / full      op, key, payload
//  result    pop / empty      status_code, slot_index, read_payload
//
// in the back end one slot of the key ram is read per cycle, lowest first,
// and the scan stops at the first hit. after reset the key ram is cleared one
// slot per cycle with full held high; up to two requests and two results wait
// in their queues, so the front end keeps taking requests while a result is
// not yet popped.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module keyed_slot_table_engine #(
	parameter int SLOTS        = 16,
	parameter int PAYLOAD_BITS = 64
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	output logic                       full,
	input  logic [1:0]                 op,
	input  logic [ksl_pkg::KEY_W-1:0]  key,
	input  logic [ksl_pkg::DATA_W-1:0] payload,
	output logic                       empty,
	input  logic                       pop,
	output logic [1:0]                 status_code,
	output logic [ksl_pkg::IDX_W-1:0]  slot_index,
	output logic [ksl_pkg::DATA_W-1:0] read_payload
);

	import ksl_pkg::*;

	req_t req;
	res_t res;
	logic req_empty;
	logic req_pop;
	logic clearing;

	// request intake
	ksl_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.op       (op),
		.key      (key),
		.payload  (payload),
		.clearing (clearing),
		.req_pop  (req_pop),
		.req_empty(req_empty),
		.req      (req)
	);

	// table scan and update
	ksl_back #(
		.SLOTS       (SLOTS),
		.PAYLOAD_BITS(PAYLOAD_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_empty(req_empty),
		.req      (req),
		.req_pop  (req_pop),
		.clearing (clearing),
		.out_pop  (pop),
		.out_empty(empty),
		.res      (res)
	);

	assign status_code  = res.status;
	assign slot_index   = res.slot_index;
	assign read_payload = res.read_payload;

	// checks
	`KSL_ASSERT_SAME(a_clear_blocks, clearing, full, "request taken during clear")
	`KSL_ASSERT_NEXT(a_req_queued, push && !full, !req_empty, "accepted request lost")
	`KSL_ASSERT_SAME(a_fail_zero, !empty && res.status != ST_DONE,
		slot_index == '0 && read_payload == '0, "failed result carries data")

endmodule

>>> rtl/ksl_ram.sv
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps

module ksl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

>>> rtl/ksl_fifo.sv
// two-entry queue of flat words
`timescale 1ns / 1ps

module ksl_fifo #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	logic [WIDTH-1:0] mem_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full    = cnt_q == 2'd2;
	assign empty   = cnt_q == 2'd0;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

>>> rtl/ksl_front.sv
// front end: takes requests, classifies the operation and queues them
`timescale 1ns / 1ps

module ksl_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	output logic                       full,
	input  logic [1:0]                 op,
	input  logic [ksl_pkg::KEY_W-1:0]  key,
	input  logic [ksl_pkg::DATA_W-1:0] payload,
	input  logic                       clearing,
	input  logic                       req_pop,
	output logic                       req_empty,
	output ksl_pkg::req_t              req
);

	import ksl_pkg::*;

	cls_t cls;
	req_t req_in;
	logic q_full;
	logic [$bits(req_t)-1:0] q_rdata;

	// decode the operation into the back end's action flags
	always_comb begin
		cls = '0;
		unique case (op_t'(op))
			OP_INSERT: begin
				cls.is_insert  = 1'b1;
				cls.wr_payload = 1'b1;
			end
			OP_DELETE: begin
				cls.clr_valid = 1'b1;
			end
			OP_MODIFY: begin
				cls.wr_payload = 1'b1;
			end
			OP_LOOKUP: begin
				cls.rd_payload = 1'b1;
			end
			default: begin
				cls = '0;
			end
		endcase
	end

	assign req_in = '{cls: cls, key: key, payload: payload};

	// no request is taken while the table is being cleared
	assign full = q_full || clearing;

	// request queue
	ksl_fifo #(
		.WIDTH($bits(req_t))
	) u_req_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push && !full),
		.wdata (req_in),
		.full  (q_full),
		.pop   (req_pop),
		.rdata (q_rdata),
		.empty (req_empty)
	);

	assign req = req_t'(q_rdata);

endmodule

>>> rtl/ksl_back.sv
// back end: scans the slot table, applies the request and queues the result
`timescale 1ns / 1ps

module ksl_back #(
	parameter int SLOTS        = 16,
	parameter int PAYLOAD_BITS = 64
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_empty,
	input  ksl_pkg::req_t req,
	output logic          req_pop,
	output logic          clearing,
	input  logic          out_pop,
	output logic          out_empty,
	output ksl_pkg::res_t res
);

	import ksl_pkg::*;

	localparam int AW = $clog2(SLOTS);
	localparam logic [AW-1:0] LAST = AW'(SLOTS - 1);

	typedef enum logic [3:0] {
		S_CLEAR = 4'b0001,
		S_IDLE  = 4'b0010,
		S_SCAN  = 4'b0100,
		S_RESP  = 4'b1000
	} state_t;

	state_t                  state_q;
	logic [AW-1:0]           scan_addr_q;
	logic                    iss_q;
	logic                    chk_s1;
	logic [AW-1:0]           idx_s1;
	req_t                    cur_q;
	res_t                    res_q;
	logic [AW-1:0]           wr_idx_q;
	logic                    do_wr_q;

	logic [KEY_W:0]          kv_rd;
	logic [KEY_W:0]          kv_wdata;
	logic [AW-1:0]           kv_waddr;
	logic                    kv_we;
	logic [PAYLOAD_BITS-1:0] pl_rd;
	logic                    pl_we;
	logic                    hit;
	logic                    last_chk;
	logic                    out_full;
	logic                    res_push;
	logic [$bits(res_t)-1:0] out_rdata;

	// compare of the slot whose address was issued in the previous cycle
	assign hit = chk_s1 && (cur_q.cls.is_insert ? !kv_rd[KEY_W] :
		(kv_rd[KEY_W] && kv_rd[KEY_W-1:0] == cur_q.key));
	assign last_chk = chk_s1 && idx_s1 == LAST;

	assign clearing = state_q == S_CLEAR;
	assign req_pop  = state_q == S_IDLE && !req_empty;
	assign res_push = state_q == S_RESP && !out_full;

	// table writes: clearing pass, insert, delete and modify
	assign kv_we    = clearing ||
		(res_push && do_wr_q && (cur_q.cls.is_insert || cur_q.cls.clr_valid));
	assign kv_waddr = clearing ? scan_addr_q : wr_idx_q;
	assign kv_wdata = clearing ? '0 : {cur_q.cls.is_insert, cur_q.key};
	assign pl_we    = res_push && do_wr_q && cur_q.cls.wr_payload;

	// sequencer and scan counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			scan_addr_q <= '0;
			iss_q       <= 1'b0;
			chk_s1      <= 1'b0;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					if (scan_addr_q == LAST) begin
						scan_addr_q <= '0;
						state_q     <= S_IDLE;
					end else begin
						scan_addr_q <= scan_addr_q + 1'b1;
					end
				end
				S_IDLE: begin
					chk_s1 <= 1'b0;
					if (!req_empty) begin
						scan_addr_q <= '0;
						iss_q       <= 1'b1;
						state_q     <= S_SCAN;
					end
				end
				S_SCAN: begin
					chk_s1 <= iss_q;
					if (hit || last_chk) begin
						iss_q   <= 1'b0;
						state_q <= S_RESP;
					end else if (iss_q) begin
						if (scan_addr_q == LAST) begin
							iss_q <= 1'b0;
						end else begin
							scan_addr_q <= scan_addr_q + 1'b1;
						end
					end
				end
				S_RESP: begin
					if (!out_full) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_CLEAR;
				end
			endcase
		end
	end

	// request, scan tag and result registers
	always_ff @(posedge clk) begin
		idx_s1 <= scan_addr_q;
		if (req_pop) begin
			cur_q <= req;
		end
		if (state_q == S_SCAN) begin
			if (hit) begin
				res_q.status       <= ST_DONE;
				res_q.slot_index   <= IDX_W'(idx_s1);
				res_q.read_payload <= cur_q.cls.rd_payload ? DATA_W'(pl_rd) : '0;
				wr_idx_q           <= idx_s1;
				do_wr_q            <= 1'b1;
			end else if (last_chk) begin
				res_q.status       <= cur_q.cls.is_insert ? ST_FULL : ST_NOT_FOUND;
				res_q.slot_index   <= '0;
				res_q.read_payload <= '0;
				do_wr_q            <= 1'b0;
			end
		end
	end

	// valid bit and key per slot
	ksl_ram #(
		.WIDTH(KEY_W + 1),
		.DEPTH(SLOTS)
	) u_key_ram (
		.clk  (clk),
		.we   (kv_we),
		.waddr(kv_waddr),
		.wdata(kv_wdata),
		.raddr(scan_addr_q),
		.rdata(kv_rd)
	);

	// payload per slot
	ksl_ram #(
		.WIDTH(PAYLOAD_BITS),
		.DEPTH(SLOTS)
	) u_pl_ram (
		.clk  (clk),
		.we   (pl_we),
		.waddr(wr_idx_q),
		.wdata(cur_q.payload[PAYLOAD_BITS-1:0]),
		.raddr(scan_addr_q),
		.rdata(pl_rd)
	);

	// result queue
	ksl_fifo #(
		.WIDTH($bits(res_t))
	) u_res_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (res_push),
		.wdata (res_q),
		.full  (out_full),
		.pop   (out_pop),
		.rdata (out_rdata),
		.empty (out_empty)
	);

	assign res = res_t'(out_rdata);

endmodule
